// ----- rtl/core/sbg_pkg.sv -----
`timescale 1ns / 1ps

package sbg_pkg;

   localparam int WORD_W  = 32;
   localparam int PROB_W  = 33;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 17;
   localparam int INDEX_W = 2;

   localparam logic [COUNT_W-1:0] MAX_LENGTH = 17'd65536;

   localparam logic [WORD_W-1:0] LFSR_TAPS = 32'hD000_0001;
   localparam logic [WORD_W-1:0] LCG_MUL   = 32'd1103515245;
   localparam logic [WORD_W-1:0] LCG_ADD   = 32'd12345;

   localparam logic [INDEX_W-1:0] CSR_PROBABILITY   = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_SOURCE_KIND   = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_SEED          = 2'd2;
   localparam logic [INDEX_W-1:0] CSR_STREAM_LENGTH = 2'd3;

   localparam logic [KIND_W-1:0] SRC_VDC  = 2'd0;
   localparam logic [KIND_W-1:0] SRC_LFSR = 2'd1;
   localparam logic [KIND_W-1:0] SRC_LCG  = 2'd2;

   localparam logic [PROB_W-1:0]  PROB_RESET   = 33'h0_8000_0000;
   localparam logic [KIND_W-1:0]  KIND_RESET   = SRC_VDC;
   localparam logic [WORD_W-1:0]  SEED_RESET   = 32'd1;
   localparam logic [COUNT_W-1:0] LENGTH_RESET = 17'd1024;

   typedef struct packed {
      logic [PROB_W-1:0]  probability;
      logic [KIND_W-1:0]  source_kind;
      logic [WORD_W-1:0]  seed;
      logic [COUNT_W-1:0] stream_length;
   } cfg_type;

   typedef struct packed {
      logic               stream_bit;
      logic [COUNT_W-1:0] ones_so_far;
      logic               last_bit;
   } result_type;

endpackage

// ----- rtl/core/sbg_csr.sv -----
`timescale 1ns / 1ps

module sbg_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sbg_pkg::INDEX_W-1:0]  csr_index,
   input  logic [sbg_pkg::PROB_W-1:0]   csr_data,
   output sbg_pkg::cfg_type             cfg
);
   import sbg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PROBABILITY:   cfg_in.probability   = csr_data;
            CSR_SOURCE_KIND:   cfg_in.source_kind   = csr_data[KIND_W-1:0];
            CSR_SEED:          cfg_in.seed          = csr_data[WORD_W-1:0];
            CSR_STREAM_LENGTH: cfg_in.stream_length = csr_data[COUNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.probability   <= PROB_RESET;
         cfg_ff.source_kind   <= KIND_RESET;
         cfg_ff.seed          <= SEED_RESET;
         cfg_ff.stream_length <= LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/sbg_gen.sv -----
`timescale 1ns / 1ps

module sbg_gen (
   input  logic                clock,
   input  logic                reset,
   input  sbg_pkg::cfg_type    cfg,
   input  logic                accept,
   input  logic                restart,
   output sbg_pkg::result_type result
);
   import sbg_pkg::*;

   logic [WORD_W-1:0]  word_ff;
   logic [WORD_W-1:0]  word_in;
   logic [COUNT_W-1:0] position_ff;
   logic [COUNT_W-1:0] position_in;
   logic [COUNT_W-1:0] ones_ff;
   logic [COUNT_W-1:0] ones_in;

   logic [WORD_W-1:0]  word_base;
   logic [COUNT_W-1:0] position_base;
   logic [COUNT_W-1:0] ones_base;
   logic [WORD_W-1:0]  word_next;
   logic [WORD_W-1:0]  fraction;
   logic [WORD_W-1:0]  lcg_word;
   logic [COUNT_W-1:0] length_eff;
   logic [COUNT_W-1:0] position_next;
   logic [COUNT_W-1:0] ones_next;
   logic               bit_value;
   logic               last_value;

   function automatic logic [WORD_W-1:0] reverse_word(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] r;
      for (int i = 0; i < WORD_W; i++) begin
         r[i] = v[WORD_W-1-i];
      end
      return r;
   endfunction

   always_comb begin
      word_base     = restart ? cfg.seed : word_ff;
      position_base = restart ? '0 : position_ff;
      ones_base     = restart ? '0 : ones_ff;
      lcg_word      = word_base * LCG_MUL + LCG_ADD;

      case (cfg.source_kind)
         SRC_VDC: begin
            fraction  = reverse_word(word_base);
            word_next = word_base + 32'd1;
         end
         SRC_LFSR: begin
            word_next = (word_base >> 1) ^ (word_base[0] ? LFSR_TAPS : '0);
            fraction  = word_next;
         end
         default: begin
            word_next = lcg_word;
            fraction  = {lcg_word[30:16], 17'd0};
         end
      endcase

      if (cfg.stream_length == '0) begin
         length_eff = 17'd1;
      end else if (cfg.stream_length > MAX_LENGTH) begin
         length_eff = MAX_LENGTH;
      end else begin
         length_eff = cfg.stream_length;
      end

      bit_value     = {1'b0, fraction} < cfg.probability;
      ones_next     = ones_base + {{(COUNT_W-1){1'b0}}, bit_value};
      position_next = position_base + 17'd1;
      last_value    = position_next >= length_eff;

      result.stream_bit  = bit_value;
      result.ones_so_far = ones_next;
      result.last_bit    = last_value;

      word_in     = word_ff;
      position_in = position_ff;
      ones_in     = ones_ff;
      if (accept) begin
         word_in     = word_next;
         position_in = last_value ? '0 : position_next;
         ones_in     = last_value ? '0 : ones_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff     <= SEED_RESET;
         position_ff <= '0;
         ones_ff     <= '0;
      end else begin
         word_ff     <= word_in;
         position_ff <= position_in;
         ones_ff     <= ones_in;
      end
   end

`ifndef SYNTHESIS
   a_ones_bounded: assert property (@(posedge clock) disable iff (reset)
      ones_ff <= position_ff)
      else $error("ones count exceeds bit position");

   a_position_bounded: assert property (@(posedge clock) disable iff (reset)
      position_ff < MAX_LENGTH)
      else $error("bit position reached the maximum length without wrap");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && last_value |=> position_ff == '0 && ones_ff == '0)
      else $error("stream counts not cleared after the last bit");
`endif

endmodule

// ----- rtl/core/stochastic_bitstream_generator.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Ports
// req     | in        | req_valid, req_ready, req_restart
// rsp     | out       | rsp_valid, rsp_ready, rsp_stream_bit, rsp_ones_so_far, rsp_last_bit
// csr     | in        | csr_valid, csr_ready, csr_index, csr_data
//
// One item per cycle while no result is stalled; each result appears in the cycle after its item is accepted.
// The generator update, compare and count run in one pass into the result register.
// Synchronous reset restores the register defaults and a generator word of 1.
// While a result stalls, req_ready is low unless that result is taken in the same cycle.

module stochastic_bitstream_generator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_stream_bit,
   output logic [sbg_pkg::COUNT_W-1:0]  rsp_ones_so_far,
   output logic                         rsp_last_bit,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sbg_pkg::INDEX_W-1:0]  csr_index,
   input  logic [sbg_pkg::PROB_W-1:0]   csr_data
);
   import sbg_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type result_ff;
   result_type result_in;
   logic       valid_ff;
   logic       valid_in;
   logic       accept;

   sbg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sbg_gen u_gen (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .accept  (accept),
      .restart (req_restart),
      .result  (result)
   );

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      result_in = accept ? result : result_ff;
      valid_in  = accept || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_stream_bit  = result_ff.stream_bit;
   assign rsp_ones_so_far = result_ff.ones_so_far;
   assign rsp_last_bit    = result_ff.last_bit;

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff)
      else $error("accepted item produced no result");

   a_restart_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_restart |=> rsp_ones_so_far == {{(COUNT_W-1){1'b0}}, rsp_stream_bit})
      else $error("restart did not clear the ones count");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(result_ff))
      else $error("result changed while stalled");
`endif

endmodule

// ----- verif/sbg_stream_checker.sv -----
`timescale 1ns / 1ps

module sbg_stream_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_restart,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_stream_bit,
   input  logic [sbg_pkg::COUNT_W-1:0] rsp_ones_so_far,
   input  logic                        rsp_last_bit,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [sbg_pkg::INDEX_W-1:0] csr_index,
   input  logic [sbg_pkg::PROB_W-1:0]  csr_data,
   output int                          error_count,
   output int                          pending_count,
   output int                          checked_count,
   output int                          stream_count
);
   import sbg_pkg::*;

   logic [PROB_W-1:0]  prob_level;
   logic [KIND_W-1:0]  source_sel;
   logic [WORD_W-1:0]  reload_word;
   logic [COUNT_W-1:0] length_cfg;
   logic [WORD_W-1:0]  gen_word;
   logic [COUNT_W-1:0] bit_index;
   logic [COUNT_W-1:0] one_count;
   result_type         expected_bits[$];
   int                 fail_tally = 0;
   int                 checked_tally = 0;
   int                 closed_tally = 0;

   assign error_count   = fail_tally;
   assign checked_count = checked_tally;
   assign stream_count  = closed_tally;

   task automatic emit_bit(input logic restart, output result_type res);
      logic [COUNT_W-1:0] limit;
      logic [WORD_W-1:0]  fraction;
      limit = length_cfg;
      if (limit == '0)
         limit = 17'd1;
      else if (limit > MAX_LENGTH)
         limit = MAX_LENGTH;
      if (restart) begin
         gen_word  = reload_word;
         bit_index = '0;
         one_count = '0;
      end
      case (source_sel)
         SRC_VDC: begin
            for (int i = 0; i < WORD_W; i++)
               fraction[i] = gen_word[WORD_W-1-i];
            gen_word = gen_word + 32'd1;
         end
         SRC_LFSR: begin
            gen_word = (gen_word >> 1) ^ (gen_word[0] ? LFSR_TAPS : '0);
            fraction = gen_word;
         end
         default: begin
            gen_word = gen_word * LCG_MUL + LCG_ADD;
            fraction = {gen_word[30:16], 17'd0};
         end
      endcase
      res.stream_bit  = ({1'b0, fraction} < prob_level);
      one_count       = one_count + {{(COUNT_W-1){1'b0}}, res.stream_bit};
      bit_index       = bit_index + 17'd1;
      res.ones_so_far = one_count;
      res.last_bit    = (bit_index >= limit);
      if (res.last_bit) begin
         bit_index = '0;
         one_count = '0;
      end
   endtask

   always @(posedge clock) begin
      result_type fresh;
      result_type want;
      if (reset) begin
         prob_level  = PROB_RESET;
         source_sel  = KIND_RESET;
         reload_word = SEED_RESET;
         length_cfg  = LENGTH_RESET;
         gen_word    = SEED_RESET;
         bit_index   = '0;
         one_count   = '0;
         expected_bits.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PROBABILITY:   prob_level  = csr_data;
               CSR_SOURCE_KIND:   source_sel  = csr_data[KIND_W-1:0];
               CSR_SEED:          reload_word = csr_data[WORD_W-1:0];
               CSR_STREAM_LENGTH: length_cfg  = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            emit_bit(req_restart, fresh);
            expected_bits.push_back(fresh);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bits.size() == 0) begin
               $error("Result arrived with no item outstanding.");
               fail_tally++;
            end else begin
               want = expected_bits.pop_front();
               if (rsp_stream_bit !== want.stream_bit) begin
                  $error("stream_bit: expected %0d, got %0d", want.stream_bit, rsp_stream_bit);
                  fail_tally++;
               end
               if (rsp_ones_so_far !== want.ones_so_far) begin
                  $error("ones_so_far: expected %0d, got %0d",
                         want.ones_so_far, rsp_ones_so_far);
                  fail_tally++;
               end
               if (rsp_last_bit !== want.last_bit) begin
                  $error("last_bit: expected %0d, got %0d", want.last_bit, rsp_last_bit);
                  fail_tally++;
               end
               checked_tally++;
               if (want.last_bit)
                  closed_tally++;
            end
         end
      end
      pending_count <= expected_bits.size();
   end

endmodule

// ----- verif/tb_stochastic_bitstream_generator.sv -----
`timescale 1ns / 1ps

module tb_stochastic_bitstream_generator;
   import sbg_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam int PART_ITEMS     = 210;

   localparam logic [KIND_W-1:0] SRC_SPARE = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_stream_bit;
   logic [COUNT_W-1:0] rsp_ones_so_far;
   logic               rsp_last_bit;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [INDEX_W-1:0] csr_index = '0;
   logic [PROB_W-1:0]  csr_data = '0;

   int error_count;
   int pending_count;
   int checked_count;
   int stream_count;
   int send_idle = 0;
   int recv_idle = 0;
   int hold_request = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int settings_used = 1;

   stochastic_bitstream_generator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_stream_bit  (rsp_stream_bit),
      .rsp_ones_so_far (rsp_ones_so_far),
      .rsp_last_bit    (rsp_last_bit),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   sbg_stream_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_stream_bit  (rsp_stream_bit),
      .rsp_ones_so_far (rsp_ones_so_far),
      .rsp_last_bit    (rsp_last_bit),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count),
      .stream_count    (stream_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding.", pending_count);
         $display("tb_stochastic_bitstream_generator: errors");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic send_bit(input logic restart);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic run_bits(input int count, input int restart_pct, input logic first_restart);
      for (int n = 0; n < count; n++)
         send_bit(n == 0 ? first_restart : ($urandom_range(99) < restart_pct));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [PROB_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [PROB_W-1:0] prob, input logic [KIND_W-1:0] kind,
                            input logic [WORD_W-1:0] seed, input logic [COUNT_W-1:0] len);
      write_reg(CSR_PROBABILITY, prob);
      write_reg(CSR_SOURCE_KIND, kind);
      write_reg(CSR_SEED, seed);
      write_reg(CSR_STREAM_LENGTH, len);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_phase(input int count);
      logic [PROB_W-1:0]  prob;
      logic [COUNT_W-1:0] len;
      case ($urandom_range(7))
         0: prob = '0;
         1: prob = 33'h1_0000_0000;
         2: prob = {1'b1, $urandom()};
         default: prob = {1'b0, $urandom()};
      endcase
      case ($urandom_range(9))
         0: len = COUNT_W'($urandom_range(65536, 131071));
         1: len = '0;
         2: len = MAX_LENGTH;
         default: len = COUNT_W'($urandom_range(1, 24));
      endcase
      drain();
      configure(prob, KIND_W'($urandom_range(3)), $urandom(), len);
      run_bits(count, 6, 1'($urandom_range(1)));
   endtask

   initial begin
      int budget;
      int count;
      send_idle = 27;
      recv_idle = 69;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset values of the registers are used before any write.
      run_bits(2, 0, 1'b0);
      run_bits(2, 0, 1'b1);
      drain();
      configure('0, SRC_VDC, 32'hFFFF_FFFF, '0);
      run_bits(3, 0, 1'b1);
      drain();
      configure(33'h1_0000_0000, SRC_LFSR, '0, 17'd3);
      run_bits(4, 0, 1'b1);
      drain();
      configure(33'h1_FFFF_FFFF, SRC_LCG, 32'hDEAD_BEEF, 17'h1_FFFF);
      run_bits(3, 0, 1'b1);
      drain();
      configure(33'h0_7FFF_FFFF, SRC_SPARE, 32'd12345, 17'd65537);
      run_bits(3, 0, 1'b1);
      drain();
      configure(PROB_RESET, SRC_VDC, 32'd5, 17'd8);
      run_bits(6, 0, 1'b1);
      // The stream is now past the shorter length, so the next bit must close it.
      drain();
      configure(PROB_RESET, SRC_VDC, 32'd9, 17'd2);
      run_bits(2, 0, 1'b0);

      for (int part = 0; part < 3; part++) begin
         send_idle = (part == 0) ? 27 : (part == 1) ? 69 : 0;
         recv_idle = (part == 0) ? 69 : (part == 1) ? 27 : 0;
         budget = PART_ITEMS;
         while (budget > 0) begin
            count = $urandom_range(15, 50);
            if (count > budget)
               count = budget;
            random_phase(count);
            budget -= count;
         end
         if (part == 0) begin
            hold_request <= hold_request + 1;
            run_bits(40, 6, 1'b0);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("Checked %0d results across %0d register settings; %0d streams ran to the end.",
               checked_count, settings_used, stream_count);
      $display("All sources, probability and length extremes, restarts and stalls were covered.");
      if (error_count == 0 && pending_count == 0)
         $display("tb_stochastic_bitstream_generator: clean");
      else
         $display("tb_stochastic_bitstream_generator: errors");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/sbg_pkg.sv
rtl/core/sbg_csr.sv
rtl/core/sbg_gen.sv
rtl/core/stochastic_bitstream_generator.sv
verif/sbg_stream_checker.sv
verif/tb_stochastic_bitstream_generator.sv
